// ----- hw/rtl/dfs_pkg.sv -----
// Shared types and constants for the depth-first topological sort block.
// No dependencies; imported by every module under hw/rtl.
package dfs_pkg;

    localparam int DEF_MAX_VERTICES = 32;
    localparam int VID_W            = 5;   // vertex id width
    localparam int ROW_W            = 32;  // adjacency row width
    localparam int CNT_W            = 6;   // vertex counts, 0..63
    localparam int LANE_W           = 8;   // row bits searched per lane
    localparam int N_LANES          = ROW_W / LANE_W;
    localparam int LIDX_W           = $clog2(LANE_W);

    typedef struct packed {
        logic [VID_W-1:0] row_index;
        logic [ROW_W-1:0] edge_bits;
        logic             last_row;
    } t_in_item;

    typedef struct packed {
        logic [VID_W-1:0] vertex_id;
        logic             last_vertex;
    } t_out_item;

    // What one lane found in its slice of the candidate row.
    typedef struct packed {
        logic              hit;
        logic [LIDX_W-1:0] idx;
    } t_lane_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_FETCH,
        ST_DECIDE,
        ST_POP,
        ST_EMIT
    } t_state;

endpackage

// ----- hw/rtl/dfs_lane.sv -----
// One search lane: masks a slice of the adjacency row and finds its lowest
// unvisited, in-use neighbor. Depends on dfs_pkg.
module dfs_lane (
    input  logic [dfs_pkg::LANE_W-1:0] i_row,
    input  logic [dfs_pkg::LANE_W-1:0] i_visited,
    input  logic [dfs_pkg::LANE_W-1:0] i_in_use,
    output dfs_pkg::t_lane_res         o_res
);
    import dfs_pkg::*;

    logic [LANE_W-1:0] cand;

    assign cand = i_row & i_in_use & ~i_visited;

    always_comb begin
        o_res.hit = 1'b0;
        o_res.idx = '0;
        for (int b = LANE_W - 1; b >= 0; b--) begin
            if (cand[b]) begin
                o_res.hit = 1'b1;
                o_res.idx = LIDX_W'(b);
            end
        end
    end

endmodule

// ----- hw/rtl/dfs_merge.sv -----
// Merge stage: picks the lowest lane that found a neighbor and forms the
// full vertex id. Depends on dfs_pkg.
module dfs_merge (
    input  dfs_pkg::t_lane_res            i_lanes [dfs_pkg::N_LANES],
    output logic                          o_found,
    output logic [dfs_pkg::VID_W-1:0]     o_vertex
);
    import dfs_pkg::*;

    always_comb begin
        o_found  = 1'b0;
        o_vertex = '0;
        for (int l = N_LANES - 1; l >= 0; l--) begin
            if (i_lanes[l].hit) begin
                o_found  = 1'b1;
                o_vertex = VID_W'(l * LANE_W) | VID_W'(i_lanes[l].idx);
            end
        end
    end

endmodule

// ----- hw/rtl/dfs_topological_sort.sv -----
// Top level of the depth-first topological sort: row store, DFS sequencer,
// search lanes and emit path. Depends on dfs_pkg, dfs_lane, dfs_merge.
// A row beat is stored on acceptance; a last-row beat starts a sort of n vertices:
// a root check per vertex plus one, fetch and decide per push and pop, a stack read per pop
// that returns to a parent. Then n result beats follow, one per cycle.
// Throughput: one row beat per cycle while idle; busy drops in the cycle of the last beat.
// Synchronous active-low reset clears control state and sets num_vertices
// to 32; the row store holds no reset value. Results cannot be stalled.
module dfs_topological_sort #(
    parameter int MAX_VERTICES = dfs_pkg::DEF_MAX_VERTICES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  dfs_pkg::t_in_item         i_item,
    output logic                      o_strobe,
    output dfs_pkg::t_out_item        o_result,
    input  logic                      i_cfg_we,
    input  logic [dfs_pkg::CNT_W-1:0] i_cfg_data
);
    import dfs_pkg::*;

    // Only 32 vertices are addressable by a row index.
    localparam int ROWS = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
    localparam int AW   = $clog2(ROWS);

    logic [ROW_W-1:0] adj_mem [ROWS];
    logic [VID_W-1:0] stk_mem [ROWS];
    logic [VID_W-1:0] fin_mem [ROWS];

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_nv;
    logic [ROW_W-1:0] r_visited, n_visited;
    logic [CNT_W-1:0] r_sp, n_sp;
    logic [CNT_W-1:0] r_fc, n_fc;
    logic [CNT_W-1:0] r_root, n_root;
    logic [VID_W-1:0] r_top, n_top;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_pend, n_pend;
    logic             r_pend_last, n_pend_last;
    logic [ROW_W-1:0] r_row;
    logic [VID_W-1:0] r_stk_rd;
    logic [VID_W-1:0] r_fin_rd;

    logic             accept;
    logic             adj_we;
    logic             stk_we;
    logic [AW-1:0]    stk_waddr, stk_raddr;
    logic [VID_W-1:0] stk_wdata;
    logic             fin_we;
    logic [AW-1:0]    fin_raddr;
    logic [CNT_W-1:0] n_used;
    logic [ROW_W-1:0] in_use;

    t_lane_res        lane_res [N_LANES];
    logic             found;
    logic [VID_W-1:0] next_v;

    assign accept = start && !busy;
    assign adj_we = accept && (CNT_W'(i_item.row_index) < CNT_W'(ROWS));
    assign n_used = (r_nv > CNT_W'(ROWS)) ? CNT_W'(ROWS) : r_nv;

    always_comb begin
        for (int v = 0; v < ROW_W; v++) begin
            in_use[v] = (CNT_W'(v) < n_used);
        end
    end

    for (genvar l = 0; l < N_LANES; l++) begin : g_lane
        dfs_lane u_lane (
            .i_row     (r_row[l*LANE_W +: LANE_W]),
            .i_visited (r_visited[l*LANE_W +: LANE_W]),
            .i_in_use  (in_use[l*LANE_W +: LANE_W]),
            .o_res     (lane_res[l])
        );
    end

    dfs_merge u_merge (
        .i_lanes  (lane_res),
        .o_found  (found),
        .o_vertex (next_v)
    );

    // Memories
    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            adj_mem[i_item.row_index[AW-1:0]] <= i_item.edge_bits;
        end
        r_row <= adj_mem[r_top[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        r_stk_rd <= stk_mem[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fin_we) begin
            fin_mem[r_fc[AW-1:0]] <= r_top;
        end
        r_fin_rd <= fin_mem[fin_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nv        <= CNT_W'(32);
            r_visited   <= '0;
            r_sp        <= '0;
            r_fc        <= '0;
            r_root      <= '0;
            r_top       <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_visited   <= n_visited;
            r_sp        <= n_sp;
            r_fc        <= n_fc;
            r_root      <= n_root;
            r_top       <= n_top;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            if (i_cfg_we) begin
                r_nv <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_visited   = r_visited;
        n_sp        = r_sp;
        n_fc        = r_fc;
        n_root      = r_root;
        n_top       = r_top;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_last = 1'b0;
        stk_we      = 1'b0;
        stk_waddr   = r_sp[AW-1:0];
        stk_wdata   = next_v;
        stk_raddr   = '0;
        fin_we      = 1'b0;
        fin_raddr   = r_idx[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept && i_item.last_row && (n_used != '0)) begin
                    n_visited = '0;
                    n_fc      = '0;
                    n_sp      = '0;
                    n_root    = '0;
                    n_state   = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (r_root >= n_used) begin
                    n_idx   = r_fc - CNT_W'(1);
                    n_state = ST_EMIT;
                end else if (r_visited[r_root[VID_W-1:0]]) begin
                    n_root = r_root + CNT_W'(1);
                end else begin
                    n_visited[r_root[VID_W-1:0]] = 1'b1;
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = r_root[VID_W-1:0];
                    n_sp      = CNT_W'(1);
                    n_top     = r_root[VID_W-1:0];
                    n_state   = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // row of the top vertex is being read
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (found) begin
                    n_visited[next_v] = 1'b1;
                    stk_we  = 1'b1;
                    n_sp    = r_sp + CNT_W'(1);
                    n_top   = next_v;
                    n_state = ST_FETCH;
                end else begin
                    fin_we = 1'b1;
                    n_fc   = r_fc + CNT_W'(1);
                    n_sp   = r_sp - CNT_W'(1);
                    if (r_sp == CNT_W'(1)) begin
                        n_root  = r_root + CNT_W'(1);
                        n_state = ST_ROOT;
                    end else begin
                        // new top sits two below the current pointer
                        stk_raddr = AW'(r_sp - CNT_W'(2));
                        n_state   = ST_POP;
                    end
                end
            end
            ST_POP: begin
                n_top   = r_stk_rd;
                n_state = ST_FETCH;
            end
            ST_EMIT: begin
                n_pend      = 1'b1;
                n_pend_last = (r_idx == '0);
                n_idx       = r_idx - CNT_W'(1);
                if (r_idx == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy                 = (r_state != ST_IDLE);
    assign o_strobe             = r_pend;
    assign o_result.vertex_id   = r_fin_rd;
    assign o_result.last_vertex = r_pend_last;

endmodule

// ----- sim/dfs_topological_sort_test.sv -----
// Self-checking bench for dfs_topological_sort: loads adjacency rows, sorts at several
// vertex counts and checks each vertex beat against an in-bench DFS predictor.
// Depends on dfs_pkg and dfs_topological_sort from hw/rtl.
module dfs_topological_sort_test;

    import dfs_pkg::*;

    localparam int NV       = DEF_MAX_VERTICES;
    localparam int WATCHDOG = 5000;   // idle cycles before giving up

    typedef enum int {
        PAT_RANDOM,
        PAT_SPARSE,
        PAT_FORWARD,
        PAT_EMPTY,
        PAT_FULL,
        PAT_CHAIN,
        PAT_BACKWARD
    } row_pat_t;

    // Predicts the topological order for every last-row beat and checks vertex beats.
    class topo_board;
        logic [ROW_W-1:0] adj_rows [NV];
        logic [CNT_W-1:0] vcount;
        t_out_item        order_due [$];
        int               errs;

        function new();
            vcount = CNT_W'(32);
            errs   = 0;
            foreach (adj_rows[i]) adj_rows[i] = '0;
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            errs++;
        endfunction

        function void set_count(logic [CNT_W-1:0] v);
            vcount = v;
        endfunction

        function void note_row(t_in_item it);
            logic [ROW_W-1:0] in_use, seen, cand;
            logic [VID_W-1:0] stk [NV];
            logic [VID_W-1:0] fin [NV];
            int               n, sp, fc, top, nxt;
            t_out_item        e;
            adj_rows[it.row_index] = it.edge_bits;
            if (!it.last_row) return;
            n = (int'(vcount) > NV) ? NV : int'(vcount);
            if (n == 0) return;
            in_use = (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
            seen   = '0;
            fc     = 0;
            for (int root = 0; root < n; root++) begin
                if (seen[root]) continue;
                seen[root] = 1'b1;
                stk[0]     = VID_W'(root);
                sp         = 1;
                while (sp > 0) begin
                    top  = int'(stk[sp-1]);
                    cand = adj_rows[top] & in_use & ~seen;
                    nxt  = 32;
                    for (int b = 31; b >= 0; b--) if (cand[b]) nxt = b;
                    if (nxt < 32 && sp < NV) begin
                        seen[nxt] = 1'b1;
                        stk[sp]   = VID_W'(nxt);
                        sp++;
                    end else begin
                        sp--;
                        if (fc < NV) begin
                            fin[fc] = VID_W'(top);
                            fc++;
                        end
                    end
                end
            end
            // emit in reverse finish order
            for (int k = 0; k < fc; k++) begin
                e.vertex_id   = fin[fc-1-k];
                e.last_vertex = (k == fc - 1);
                order_due.push_back(e);
            end
        endfunction

        function void check_vertex(t_out_item got);
            t_out_item want;
            if (order_due.size() == 0) begin
                report($sformatf("vertex beat %0d with nothing expected", got.vertex_id));
                return;
            end
            want = order_due.pop_front();
            if (got.vertex_id !== want.vertex_id)
                report($sformatf("vertex_id got %0d want %0d", got.vertex_id, want.vertex_id));
            if (got.last_vertex !== want.last_vertex)
                report($sformatf("last_vertex got %0b want %0b on vertex %0d",
                                 got.last_vertex, want.last_vertex, want.vertex_id));
        endfunction
    endclass

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             busy;
    t_in_item         i_item     = '0;
    logic             o_strobe;
    t_out_item        o_result;
    logic             i_cfg_we   = 1'b0;
    logic [CNT_W-1:0] i_cfg_data = '0;

    topo_board        sb;
    logic [NV-1:0]    rows_loaded = '0;
    int               beats_sent  = 0;
    int               burst_left  = 0;
    bit               pacing_on   = 1'b1;
    int               stall_cycles = 0;

    dfs_topological_sort u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // sender bursts with random gaps
    task automatic pace();
        int gap;
        if (!pacing_on) return;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_row(int row, logic [ROW_W-1:0] bits, logic last);
        t_in_item it;
        pace();
        it.row_index = VID_W'(row);
        it.edge_bits = bits;
        it.last_row  = last;
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_row(it);
        rows_loaded[row] = 1'b1;
        beats_sent++;
    endtask

    // only while idle: all vertex beats in, then a margin for a sort that emits nothing
    task automatic write_count(logic [CNT_W-1:0] v);
        start <= 1'b0;
        while (sb.order_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        i_cfg_data <= v;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_count(v);
    endtask

    function automatic logic [ROW_W-1:0] make_row(row_pat_t pat, int v);
        case (pat)
            PAT_RANDOM:   return $urandom;
            PAT_SPARSE:   return $urandom & $urandom & $urandom;
            PAT_FORWARD:  return $urandom & ~((32'd2 << v) - 32'd1);
            PAT_EMPTY:    return '0;
            PAT_FULL:     return '1;
            PAT_CHAIN:    return 32'd1 << (v + 1);
            default:      return $urandom & ((32'd1 << v) - 32'd1);
        endcase
    endfunction

    // Every row a sort will read is loaded before the last-row beat.
    task automatic run_graph(int n_eff);
        row_pat_t pat;
        int       extra, r;
        pat = row_pat_t'($urandom_range(0, 6));
        for (int v = 0; v < NV; v++)
            if (v < n_eff && !rows_loaded[v]) send_row(v, make_row(pat, v), 1'b0);
        extra = $urandom_range(0, 5);
        repeat (extra) begin
            r = $urandom_range(0, NV - 1);
            send_row(r, make_row(pat, r), 1'b0);
        end
        // now and then the sequence is left without its last row
        if ($urandom_range(0, 9) != 0) begin
            r = $urandom_range(0, NV - 1);
            send_row(r, make_row(pat, r), 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1) sb.check_vertex(o_result);
            if (o_strobe === 1'b1 || (start && !busy) || i_cfg_we)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int               cnt, n_eff, runs;
        logic [CNT_W-1:0] pick;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single vertex, self-loop and edges beyond the count
        write_count(CNT_W'(1));
        send_row(0, 32'hFFFF_FFFF, 1'b1);

        // four-vertex chain closed into a cycle, high bits set in row 2
        write_count(CNT_W'(4));
        send_row(1, 32'h0000_0004, 1'b0);
        send_row(2, 32'hFFFF_FFF8, 1'b0);
        send_row(0, 32'h0000_0002, 1'b0);
        send_row(3, 32'h0000_0001, 1'b1);
        // re-sort on rows kept from the last graph
        send_row(3, 32'h0000_0000, 1'b1);
        send_row(2, 32'h0000_0000, 1'b1);
        send_row(0, 32'h0000_000C, 1'b1);

        // two vertices pointing at each other, plus a row outside the count
        write_count(CNT_W'(2));
        send_row(31, 32'hFFFF_FFFF, 1'b0);
        send_row(1, 32'h0000_0001, 1'b0);
        send_row(0, 32'h0000_0003, 1'b1);
        send_row(31, 32'h0000_0000, 1'b1);

        // zero vertices: last row stores but emits nothing
        write_count(CNT_W'(0));
        send_row(5, 32'hA5A5_5A5A, 1'b1);
        send_row(0, 32'h5A5A_A5A5, 1'b0);

        // random phases; the first fills the whole store
        cnt = 0;
        while (beats_sent < 300) begin
            if (cnt == 0)      pick = CNT_W'(32);
            else if (cnt == 1) pick = CNT_W'(63);
            else begin
                case ($urandom_range(0, 9))
                    0:       pick = CNT_W'(0);
                    1:       pick = CNT_W'(1);
                    2:       pick = CNT_W'(32);
                    3:       pick = CNT_W'(63);
                    4:       pick = CNT_W'($urandom_range(33, 62));
                    5:       pick = CNT_W'(2);
                    default: pick = CNT_W'($urandom_range(3, 31));
                endcase
            end
            write_count(pick);
            pacing_on = ($urandom_range(0, 3) != 0);
            n_eff = (int'(pick) > NV) ? NV : int'(pick);
            runs  = $urandom_range(1, 5);
            repeat (runs) run_graph(n_eff);
            cnt++;
        end
        start <= 1'b0;

        while (sb.order_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.order_due.size() != 0)
            sb.report($sformatf("%0d vertex beats never arrived", sb.order_due.size()));
        if (sb.errs == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/dfs_pkg.sv
hw/rtl/dfs_lane.sv
hw/rtl/dfs_merge.sv
hw/rtl/dfs_topological_sort.sv
sim/dfs_topological_sort_test.sv
